// File: design/gqv_pkg.sv
// Shared types and constants for the glyph quad vertex generator.
`timescale 1ns / 1ps
package gqv_pkg;
    localparam int MAX_CHARS_DEF     = 128;
    localparam int GLYPH_ENTRIES_DEF = 256;
    localparam int TEX_BITS_DEF      = 12;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_UPPER_COLOR = 3'd2;
    localparam logic [2:0] REG_LOWER_COLOR = 3'd3;
    localparam logic [2:0] REG_TEX_WIDTH   = 3'd4;
    localparam logic [2:0] REG_TEX_HEIGHT  = 3'd5;
    localparam logic [2:0] REG_FONT_HEIGHT = 3'd6;
    localparam logic [2:0] REG_FIXED_FEED  = 3'd7;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Work handed from the front end to the back end: one mapped character.
    typedef struct packed {
        logic [6:0]  slot_lo;
        logic [15:0] pen;
        logic [11:0] gx;
        logic [11:0] gy;
        logic [11:0] gw;
        logic [11:0] gh;
    } job_t;
endpackage

// File: design/glyph_quad_vertex_generator_unit.sv
// Top level of the glyph quad vertex generator.
// Flow: a character item goes through the table read, the decision and the 29-step divider,
// then gives four vertices, one per cycle while m_tready is high.
// The front end can accept the next item while the back end still divides or emits the last one.
// Reset (aresetn low, synchronous) clears the glyph valid bits, pen and slot, and resets the registers to defaults.
`timescale 1ns / 1ps
module glyph_quad_vertex_generator_unit #(
    parameter int MAX_CHARS     = gqv_pkg::MAX_CHARS_DEF,
    parameter int GLYPH_ENTRIES = gqv_pkg::GLYPH_ENTRIES_DEF,
    parameter int TEX_BITS      = gqv_pkg::TEX_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // char_code, first_of_string, glyph_x, y, w, h, pad
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [111:0] m_tdata,  // vertex_index, pos_x, pos_y, tex_u, tex_v, color, pad
    output logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import gqv_pkg::*;

    logic [15:0] ox_reg, oy_reg;
    logic [31:0] uc_reg, lc_reg;
    logic [12:0] tw_reg, th_reg;
    logic [10:0] fh_reg;
    logic        ff_reg;
    logic        jv, jr;
    job_t        job;
    logic [8:0]  vi;
    logic [15:0] px, py;
    logic [16:0] tu, tv;
    logic [31:0] col;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg <= '0; oy_reg <= '0;
            uc_reg <= 32'hFFFFFFFF; lc_reg <= 32'hFFFFFFFF;
            tw_reg <= 13'd256; th_reg <= 13'd256;
            fh_reg <= 11'd16; ff_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X:    ox_reg <= cfg_data[15:0];
                REG_ORIGIN_Y:    oy_reg <= cfg_data[15:0];
                REG_UPPER_COLOR: uc_reg <= cfg_data;
                REG_LOWER_COLOR: lc_reg <= cfg_data;
                REG_TEX_WIDTH:   tw_reg <= cfg_data[12:0];
                REG_TEX_HEIGHT:  th_reg <= cfg_data[12:0];
                REG_FONT_HEIGHT: fh_reg <= cfg_data[10:0];
                REG_FIXED_FEED:  ff_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    gqv_front #(.MAX_CHARS(MAX_CHARS), .GLYPH_ENTRIES(GLYPH_ENTRIES), .TEX_BITS(TEX_BITS))
    u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .func(s_tuser),
        .char_code(s_tdata[15:0]), .first_of_string(s_tdata[16]),
        .glyph_x(s_tdata[28:17]), .glyph_y(s_tdata[40:29]),
        .glyph_w(s_tdata[52:41]), .glyph_h(s_tdata[64:53]),
        .font_height(fh_reg), .fixed_feed(ff_reg),
        .job_valid(jv), .job_ready(jr), .job
    );

    gqv_back u_back (
        .aclk, .aresetn, .job_valid(jv), .job_ready(jr), .job,
        .origin_x(ox_reg), .origin_y(oy_reg), .upper_color(uc_reg), .lower_color(lc_reg),
        .tex_width(tw_reg), .tex_height(th_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .vertex_index(vi), .pos_x(px), .pos_y(py), .tex_u(tu), .tex_v(tv),
        .color(col), .last(m_tlast)
    );

    assign m_tdata = {5'h0, col, tv, tu, py, px, vi};
endmodule

// File: design/gqv_div.sv
// Restoring divider: floor((edge << 16) / div), saturated at one in Q1.16.
`timescale 1ns / 1ps
module gqv_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [12:0] edge_in,
    input  logic [12:0] div_in,
    output logic        done,
    output logic [16:0] quot
);
    import gqv_pkg::*;

    logic [28:0] num_reg, num_next;
    logic [13:0] rem_reg, rem_next;
    logic [12:0] div_reg, div_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [28:0] q_reg, q_next;
    logic [14:0] trial;

    assign trial = {rem_reg, num_reg[28]} - {2'b0, div_reg};

    // Shift one numerator bit per cycle while busy.
    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_next    = q_reg;
        if (start) begin
            num_next  = {edge_in, 16'h0};
            rem_next  = '0;
            div_next  = div_in;
            cnt_next  = 5'd29;
            busy_next = 1'b1;
            q_next    = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[27:0], 1'b0};
            if (!trial[14]) begin
                rem_next = trial[13:0];
                q_next   = {q_reg[27:0], 1'b1};
            end else begin
                rem_next = {rem_reg[12:0], num_reg[28]};
                q_next   = {q_reg[27:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    assign done = !busy_reg;
    assign quot = (div_reg == 13'd0 || q_reg > {12'h0, ONE_Q16}) ? ONE_Q16 : q_reg[16:0];
endmodule

// File: design/gqv_front.sv
// Front end: glyph table, slot and pen bookkeeping, job issue.
`timescale 1ns / 1ps
module gqv_front #(
    parameter int MAX_CHARS     = gqv_pkg::MAX_CHARS_DEF,
    parameter int GLYPH_ENTRIES = gqv_pkg::GLYPH_ENTRIES_DEF,
    parameter int TEX_BITS      = gqv_pkg::TEX_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [15:0]       char_code,
    input  logic              first_of_string,
    input  logic [11:0]       glyph_x,
    input  logic [11:0]       glyph_y,
    input  logic [11:0]       glyph_w,
    input  logic [11:0]       glyph_h,
    input  logic [10:0]       font_height,
    input  logic              fixed_feed,
    output logic              job_valid,
    input  logic              job_ready,
    output gqv_pkg::job_t     job
);
    import gqv_pkg::*;

    localparam int AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int SW = $clog2(MAX_CHARS + 1);
    localparam logic [11:0] TMASK = 12'((32'd1 << TEX_BITS) - 1);

    // Stage 0: accept; stage 1: table read done, decide.
    logic [47:0]            mem [GLYPH_ENTRIES];
    logic [GLYPH_ENTRIES-1:0] vld_reg;
    logic [47:0]            rd_reg;
    logic                   s1_reg, s1_hit_reg, s1_ascii_reg, s1_first_reg;
    logic [SW-1:0]          slot_reg;
    logic [15:0]            pen_reg;
    logic                   jv_reg;
    job_t                   job_reg;
    logic [AW-1:0]          addr;
    logic                   in_range, accept;
    logic [SW-1:0]          cur_slot;
    logic [15:0]            cur_pen;
    logic [16:0]            pen_sum;
    logic [11:0]            feed;

    assign addr     = char_code[AW-1:0];
    assign in_range = (32'(char_code) < GLYPH_ENTRIES);
    assign in_ready = !s1_reg && !jv_reg;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (accept && !func && in_range)
            mem[addr] <= {glyph_x & TMASK, glyph_y & TMASK, glyph_w & TMASK, glyph_h & TMASK};
        rd_reg <= mem[addr];
    end

    assign cur_slot = s1_first_reg ? '0 : slot_reg;
    assign cur_pen  = s1_first_reg ? '0 : pen_reg;
    assign feed     = (fixed_feed && s1_ascii_reg) ? {2'b0, font_height[10:1]} : rd_reg[23:12];
    assign pen_sum  = {1'b0, cur_pen} + {5'b0, feed} + 17'd1;

    // Update slot and pen, queue one job per mapped character below the slot limit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            s1_reg   <= 1'b0;
            slot_reg <= '0;
            pen_reg  <= '0;
            jv_reg   <= 1'b0;
        end else begin
            if (accept && !func && in_range) vld_reg[addr] <= 1'b1;
            s1_reg <= accept && func;
            if (jv_reg && job_ready) jv_reg <= 1'b0;
            if (s1_reg) begin
                if (32'(cur_slot) >= MAX_CHARS) begin
                    slot_reg <= cur_slot;
                    pen_reg  <= cur_pen;
                end else begin
                    slot_reg <= cur_slot + SW'(1);
                    if (s1_hit_reg) begin
                        pen_reg <= pen_sum[16] ? 16'hFFFF : pen_sum[15:0];
                        jv_reg  <= 1'b1;
                    end else begin
                        pen_reg <= cur_pen;
                    end
                end
            end
        end
        if (accept) begin
            s1_hit_reg   <= in_range && vld_reg[addr];
            s1_ascii_reg <= (char_code < 16'd128);
            s1_first_reg <= first_of_string;
        end
        if (s1_reg) begin
            job_reg.slot_lo <= 7'(cur_slot);
            job_reg.pen     <= cur_pen;
            job_reg.gx      <= rd_reg[47:36];
            job_reg.gy      <= rd_reg[35:24];
            job_reg.gw      <= rd_reg[23:12];
            job_reg.gh      <= rd_reg[11:0];
        end
    end

    assign job_valid = jv_reg;
    assign job       = job_reg;

    // A queued job never coexists with a decision in flight.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(jv_reg && s1_reg))
        else $error("job and decision overlap");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn) s1_reg |-> !in_ready)
        else $error("accept during decide");
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(slot_reg) <= MAX_CHARS) else $error("slot overflow");
endmodule

// File: design/gqv_back.sv
// Back end: divides edges by texture size and emits four vertices.
`timescale 1ns / 1ps
module gqv_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  gqv_pkg::job_t job,
    input  logic [15:0]   origin_x,
    input  logic [15:0]   origin_y,
    input  logic [31:0]   upper_color,
    input  logic [31:0]   lower_color,
    input  logic [12:0]   tex_width,
    input  logic [12:0]   tex_height,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [8:0]    vertex_index,
    output logic [15:0]   pos_x,
    output logic [15:0]   pos_y,
    output logic [16:0]   tex_u,
    output logic [16:0]   tex_v,
    output logic [31:0]   color,
    output logic          last
);
    import gqv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  st_reg;
    logic [1:0]  k_reg;
    logic        go_reg;
    job_t        j_reg;
    logic [16:0] u0, u1, v0, v1;
    logic        d0, d1, d2, d3;
    logic        take;
    logic [17:0] x0, x1, y1;
    logic [15:0] x0s, x1s, y1s;

    assign job_ready = (st_reg == ST_IDLE);
    assign take      = job_valid && job_ready;

    gqv_div u_du0 (.aclk, .aresetn, .start(take), .edge_in({1'b0, job.gx}),
                   .div_in(tex_width), .done(d0), .quot(u0));
    gqv_div u_du1 (.aclk, .aresetn, .start(take),
                   .edge_in({1'b0, job.gx} + {1'b0, job.gw}),
                   .div_in(tex_width), .done(d1), .quot(u1));
    gqv_div u_dv0 (.aclk, .aresetn, .start(take), .edge_in({1'b0, job.gy}),
                   .div_in(tex_height), .done(d2), .quot(v0));
    gqv_div u_dv1 (.aclk, .aresetn, .start(take),
                   .edge_in({1'b0, job.gy} + {1'b0, job.gh}),
                   .div_in(tex_height), .done(d3), .quot(v1));

    // Saturate positions to 16 bits signed.
    function automatic logic [15:0] sat(input logic [17:0] v);
        if (!v[17] && v[16:15] != 2'b00) return 16'h7FFF;
        if (v[17] && v[16:15] != 2'b11) return 16'h8000;
        return v[15:0];
    endfunction

    assign x0  = {{2{origin_x[15]}}, origin_x} + {2'b0, j_reg.pen};
    assign x1  = x0 + {6'b0, j_reg.gw};
    assign y1  = {{2{origin_y[15]}}, origin_y} + {6'b0, j_reg.gh};
    assign x0s = sat(x0);
    assign x1s = sat(x1);
    assign y1s = sat(y1);

    // Sequence: wait for dividers, then walk the four corners.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            k_reg  <= '0;
            go_reg <= 1'b0;
        end else begin
            go_reg <= take;
            case (st_reg)
                ST_IDLE: if (take) st_reg <= ST_DIV;
                ST_DIV:  if (!go_reg && d0 && d1 && d2 && d3) begin
                    st_reg <= ST_EMIT;
                    k_reg  <= '0;
                end
                ST_EMIT: if (out_ready) begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
        if (take) j_reg <= job;
    end

    assign out_valid    = (st_reg == ST_EMIT);
    assign vertex_index = {j_reg.slot_lo, k_reg};
    assign pos_x        = k_reg[0] ? x1s : x0s;
    assign pos_y        = k_reg[1] ? y1s : origin_y;
    assign tex_u        = k_reg[0] ? u1 : u0;
    assign tex_v        = k_reg[1] ? v1 : v0;
    assign color        = k_reg[1] ? lower_color : upper_color;
    assign last         = (k_reg == 2'd3);

    a_k: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_EMIT) |=> (st_reg != ST_EMIT) || (k_reg == 2'd0))
        else $error("corner count not restarted");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (d0 && d1 && d2 && d3)) else $error("emit before divide");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (st_reg == ST_DIV)) else $error("job lost");
endmodule

// File: tb/tb_top.sv
// Testbench for the glyph quad vertex generator: scoreboard, drivers and stimulus.
`timescale 1ns / 1ps

// One expected or observed quad corner.
typedef struct {
    logic [8:0]         vidx;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [16:0]        u;
    logic [16:0]        v;
    logic [31:0]        color;
    logic               last;
} quad_vertex_t;

// Tracks glyph table, pen and slot, and holds the corners still to come.
class glyph_quad_scoreboard;
    int              org_x, org_y;
    logic [31:0]     top_color, bottom_color;
    int unsigned     tex_w, tex_h, font_h;
    bit              fixed_adv;
    logic [11:0]     rx [256], ry [256], rw [256], rh [256];
    bit              mapped [256];
    int unsigned     pen, slot;
    quad_vertex_t    pending_corners [$];
    int              errors;

    function new();
        org_x = 0; org_y = 0;
        top_color = 32'hFFFF_FFFF; bottom_color = 32'hFFFF_FFFF;
        tex_w = 256; tex_h = 256; font_h = 16; fixed_adv = 0;
        foreach (mapped[i]) mapped[i] = 0;
        pen = 0; slot = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            gqv_pkg::REG_ORIGIN_X:    org_x = $signed(val[15:0]);
            gqv_pkg::REG_ORIGIN_Y:    org_y = $signed(val[15:0]);
            gqv_pkg::REG_UPPER_COLOR: top_color = val;
            gqv_pkg::REG_LOWER_COLOR: bottom_color = val;
            gqv_pkg::REG_TEX_WIDTH:   tex_w = val[12:0];
            gqv_pkg::REG_TEX_HEIGHT:  tex_h = val[12:0];
            gqv_pkg::REG_FONT_HEIGHT: font_h = val[10:0];
            gqv_pkg::REG_FIXED_FEED:  fixed_adv = val[0];
            default: ;
        endcase
    endfunction

    function logic [16:0] tex_coord(int unsigned edge_t, int unsigned div);
        longint unsigned q;
        if (div == 0) return gqv_pkg::ONE_Q16;
        q = (longint'(edge_t) << 16) / div;
        return (q > 65536) ? gqv_pkg::ONE_Q16 : q[16:0];
    endfunction

    function logic signed [15:0] clamp16(int p);
        if (p > 32767) return 16'sd32767;
        if (p < -32768) return -16'sd32768;
        return p[15:0];
    endfunction

    // Note an accepted item and queue the corners it causes.
    function void note_item(bit func, logic [15:0] code, bit first,
                            logic [11:0] gx, gy, gw, gh);
        int           xs [2];
        int           ys [2];
        logic [16:0]  us [2];
        logic [16:0]  vs [2];
        quad_vertex_t c;
        int unsigned  adv;
        if (!func) begin
            if (code < 256) begin
                rx[code] = gx; ry[code] = gy; rw[code] = gw; rh[code] = gh;
                mapped[code] = 1;
            end
            return;
        end
        if (first) begin
            pen = 0; slot = 0;
        end
        if (slot >= gqv_pkg::MAX_CHARS_DEF) return;
        slot++;
        if (code >= 256 || !mapped[code]) return;
        us[0] = tex_coord(rx[code], tex_w);
        us[1] = tex_coord(rx[code] + rw[code], tex_w);
        vs[0] = tex_coord(ry[code], tex_h);
        vs[1] = tex_coord(ry[code] + rh[code], tex_h);
        xs[0] = org_x + int'(pen);
        xs[1] = xs[0] + int'(rw[code]);
        ys[0] = org_y;
        ys[1] = org_y + int'(rh[code]);
        for (int k = 0; k < 4; k++) begin
            c.vidx  = 9'((slot - 1) * 4 + k);
            c.px    = clamp16(xs[k & 1]);
            c.py    = clamp16(ys[k >> 1]);
            c.u     = us[k & 1];
            c.v     = vs[k >> 1];
            c.color = (k >> 1) ? bottom_color : top_color;
            c.last  = (k == 3);
            pending_corners.push_back(c);
        end
        adv = (fixed_adv && code < 128) ? font_h / 2 : rw[code];
        pen += adv + 1;
        if (pen > 65535) pen = 65535;
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Compare one accepted corner with the oldest expectation.
    task check_corner(quad_vertex_t got);
        quad_vertex_t w;
        if (pending_corners.size() == 0) begin
            report($sformatf("unexpected vertex index %0d", got.vidx));
            return;
        end
        w = pending_corners.pop_front();
        if (got.vidx !== w.vidx)
            report($sformatf("vertex_index %0d want %0d", got.vidx, w.vidx));
        if (got.px !== w.px) report($sformatf("pos_x %0d want %0d", got.px, w.px));
        if (got.py !== w.py) report($sformatf("pos_y %0d want %0d", got.py, w.py));
        if (got.u !== w.u) report($sformatf("tex_u %0h want %0h", got.u, w.u));
        if (got.v !== w.v) report($sformatf("tex_v %0h want %0h", got.v, w.v));
        if (got.color !== w.color)
            report($sformatf("color %0h want %0h", got.color, w.color));
        if (got.last !== w.last) report($sformatf("last %0b want %0b", got.last, w.last));
    endtask
endclass

module tb_top;
    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    glyph_quad_scoreboard sb;
    int  hold_off;
    bit  no_gaps;
    int  loaded_codes [$];

    glyph_quad_vertex_generator_unit i_dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("tb_top failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function int random_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off when asked.
    initial begin
        quad_vertex_t got;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 0;
            end else begin
                m_tready <= (random_gap() == 0);
            end
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.vidx  = m_tdata[8:0];
                got.px    = m_tdata[24:9];
                got.py    = m_tdata[40:25];
                got.u     = m_tdata[57:41];
                got.v     = m_tdata[74:58];
                got.color = m_tdata[106:75];
                got.last  = m_tlast;
                sb.check_corner(got);
            end
        end
    end

    task write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    // Offer one item and hold it until accepted.
    task send_item(bit func, logic [15:0] code, bit first,
                   logic [11:0] gx, gy, gw, gh);
        logic [71:0] packed_item;
        int gap;
        gap = random_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        packed_item = {7'd0, gh, gw, gy, gx, first, code};
        s_tvalid <= 1;
        s_tuser  <= func;
        s_tdata  <= packed_item;
        forever begin
            @(negedge aclk);
            if (s_tready) break;
            @(posedge aclk);
        end
        @(posedge aclk);
        sb.note_item(func, code, first, gx, gy, gw, gh);
    endtask

    task load_glyph(logic [15:0] code, logic [11:0] gx, gy, gw, gh);
        send_item(0, code, 0, gx, gy, gw, gh);
        if (code < 256) loaded_codes.push_back(code);
    endtask

    task place_char(logic [15:0] code, bit first);
        send_item(1, code, first, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    // Drain all expected corners, then let an unmapped character finish.
    task wait_drained();
        s_tvalid <= 0;
        while (sb.pending_corners.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function logic [11:0] random_width();
        return ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
    endfunction

    task random_config(int mode);
        logic [31:0] ox, oy, tw, th, fh;
        case (mode)
            0: begin
                ox = 32'hFFFF_8000; oy = 32'hFFFF_8000; tw = 1; th = 1; fh = 1;
            end
            1: begin
                ox = 32'h7FFF; oy = 32'h7FFF; tw = 4096; th = 4096; fh = 1024;
            end
            2: begin
                ox = 0; oy = 0; tw = 0; th = 8191; fh = 2047;
            end
            default: begin
                ox = $urandom_range(0, 9) < 7 ? $urandom_range(0, 400) : $urandom;
                oy = $urandom_range(0, 9) < 7 ? $urandom_range(0, 400) : $urandom;
                tw = $urandom_range(1, 4096);
                th = $urandom_range(1, 4096);
                fh = $urandom_range(1, 1024);
            end
        endcase
        write_reg(gqv_pkg::REG_ORIGIN_X, ox);
        write_reg(gqv_pkg::REG_ORIGIN_Y, oy);
        write_reg(gqv_pkg::REG_UPPER_COLOR, $urandom);
        write_reg(gqv_pkg::REG_LOWER_COLOR, $urandom);
        write_reg(gqv_pkg::REG_TEX_WIDTH, tw);
        write_reg(gqv_pkg::REG_TEX_HEIGHT, th);
        write_reg(gqv_pkg::REG_FONT_HEIGHT, fh);
        write_reg(gqv_pkg::REG_FIXED_FEED, $urandom_range(0, 1));
    endtask

    // One string: mostly loaded glyphs, some unmapped or out-of-table codes.
    task random_string(int len);
        int r;
        logic [15:0] code;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80 && loaded_codes.size() > 0)
                code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
            else if (r < 90)
                code = $urandom_range(0, 255);
            else
                code = $urandom;
            place_char(code, i == 0 || $urandom_range(0, 49) == 0);
        end
    endtask

    initial begin
        sb = new();
        hold_off = 0;
        no_gaps = 0;
        aresetn = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = 0;
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: field extremes, unmapped codes, table edges, fixed feed.
        place_char(16'd65, 1);
        load_glyph(16'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        load_glyph(16'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        load_glyph(16'd65, 12'd10, 12'd20, 12'd8, 12'd7);
        load_glyph(16'd200, 12'd128, 12'd64, 12'd30, 12'd5);
        load_glyph(16'hFFFF, 12'd1, 12'd1, 12'd1, 12'd1);
        load_glyph(16'd256, 12'd1, 12'd1, 12'd1, 12'd1);
        place_char(16'd0, 1);
        place_char(16'd255, 0);
        place_char(16'd65, 0);
        place_char(16'd256, 0);
        place_char(16'd66, 0);
        place_char(16'hFFFF, 0);
        place_char(16'd200, 0);
        place_char(16'd65, 1);
        wait_drained();
        write_reg(gqv_pkg::REG_FIXED_FEED, 1);
        write_reg(gqv_pkg::REG_FONT_HEIGHT, 11'd1024);
        write_reg(gqv_pkg::REG_ORIGIN_X, 32'h7FF0);
        place_char(16'd65, 1);
        place_char(16'd200, 0);
        place_char(16'd65, 0);
        place_char(16'd255, 0);
        wait_drained();

        for (int phase = 0; phase < 7; phase++) begin
            random_config(phase);
            no_gaps = (phase == 4);
            repeat (12) load_glyph($urandom_range(0, 255), 12'($urandom), 12'($urandom),
                                   random_width(), 12'($urandom));
            if ($urandom_range(0, 1)) load_glyph($urandom_range(256, 65535), 1, 1, 1, 1);
            if (phase == 3) begin
                // Long receiver hold-off while characters keep coming.
                hold_off = 400;
                random_string(15);
            end
            repeat (5) random_string($urandom_range(1, 10));
            if (phase == 5) begin
                // Run past the slot limit, then restart.
                random_string(135);
                place_char(loaded_codes[0], 1);
            end
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending_corners.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
